[sv/mdpp_pkg.sv]
// Package with the types, character codes and name tables of the descriptor parser.
`timescale 1ns / 1ps

package mdpp_pkg;

    // Parser phases.
    localparam logic [1:0] PH_SEEK  = 2'd0;
    localparam logic [1:0] PH_PARAM = 2'd1;
    localparam logic [1:0] PH_NAME  = 2'd2;
    localparam logic [1:0] PH_DRAIN = 2'd3;

    // Descriptor characters.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_Z      = 8'h5A;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_L      = 8'h4C;

    // Type codes.
    localparam logic [3:0] TC_Z      = 4'd0;
    localparam logic [3:0] TC_B      = 4'd1;
    localparam logic [3:0] TC_C      = 4'd2;
    localparam logic [3:0] TC_S      = 4'd3;
    localparam logic [3:0] TC_I      = 4'd4;
    localparam logic [3:0] TC_J      = 4'd5;
    localparam logic [3:0] TC_F      = 4'd6;
    localparam logic [3:0] TC_D      = 4'd7;
    localparam logic [3:0] TC_STRING = 4'd8;
    localparam logic [3:0] TC_CLASS  = 4'd9;
    localparam logic [3:0] TC_OBJECT = 4'd10;

    // End reasons.
    localparam logic [2:0] ER_CLOSE_PAREN   = 3'd0;
    localparam logic [2:0] ER_BEFORE_PAREN  = 3'd1;
    localparam logic [2:0] ER_NO_OPEN_PAREN = 3'd2;
    localparam logic [2:0] ER_BAD_LETTER    = 3'd3;
    localparam logic [2:0] ER_UNTERMINATED  = 3'd4;

    localparam logic [4:0] LEN_STRING = 5'd16;
    localparam logic [4:0] LEN_CLASS  = 5'd15;
    localparam logic [4:0] POS_MAX    = 5'd31;

    typedef struct packed {
        logic [1:0] phase;
        logic       seen_bracket;
        logic [4:0] match_pos;
        logic       still_string;
        logic       still_class;
    } t_state;

    typedef struct packed {
        logic       is_end;
        logic [3:0] type_code;
        logic       array_flag;
        logic [2:0] end_reason;
    } t_result;

    // Characters of "java/lang/String".
    function automatic logic [7:0] string_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h6A; // j
            4'd1:    ch = 8'h61; // a
            4'd2:    ch = 8'h76; // v
            4'd3:    ch = 8'h61; // a
            4'd4:    ch = 8'h2F; // /
            4'd5:    ch = 8'h6C; // l
            4'd6:    ch = 8'h61; // a
            4'd7:    ch = 8'h6E; // n
            4'd8:    ch = 8'h67; // g
            4'd9:    ch = 8'h2F; // /
            4'd10:   ch = 8'h53; // S
            4'd11:   ch = 8'h74; // t
            4'd12:   ch = 8'h72; // r
            4'd13:   ch = 8'h69; // i
            4'd14:   ch = 8'h6E; // n
            default: ch = 8'h67; // g
        endcase
        return ch;
    endfunction

    // Characters of "java/lang/Class"; the last index is never compared.
    function automatic logic [7:0] class_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h6A;
            4'd1:    ch = 8'h61;
            4'd2:    ch = 8'h76;
            4'd3:    ch = 8'h61;
            4'd4:    ch = 8'h2F;
            4'd5:    ch = 8'h6C;
            4'd6:    ch = 8'h61;
            4'd7:    ch = 8'h6E;
            4'd8:    ch = 8'h67;
            4'd9:    ch = 8'h2F;
            4'd10:   ch = 8'h43; // C
            4'd11:   ch = 8'h6C; // l
            4'd12:   ch = 8'h61; // a
            4'd13:   ch = 8'h73; // s
            4'd14:   ch = 8'h73; // s
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[sv/method_descriptor_param_parser.sv]
// Top level of the method descriptor parameter parser.
`timescale 1ns / 1ps
// A byte that produces an item shows it on the outputs in the cycle after the byte is accepted.
// Throughput: one byte per cycle; a request is taken whenever the output register is
// empty or is being emptied in the same cycle, so the output ready sets the pace.
// Reset (synchronous, active low) empties the output register and returns the parser
// to seeking the open parenthesis with cleared parameter tracking.

module method_descriptor_param_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_is_end,
    output logic [3:0] o_type_code,
    output logic       o_array_flag,
    output logic [2:0] o_end_reason
);

    // Parser state: phase, bracket flag and the running class-name match.
    mdpp_pkg::t_state  r_state;
    mdpp_pkg::t_state  n_state;

    // Output register holding one finished item until the consumer takes it.
    logic              r_out_valid;
    mdpp_pkg::t_result r_out;

    logic              w_emit;
    mdpp_pkg::t_result w_result;
    logic              w_accept;

    // The output register frees up in the same cycle it is read, so a new
    // request can be taken every cycle while the consumer keeps up.
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    mdpp_step u_step (
        .i_state  (r_state),
        .i_char   (i_char_in),
        .o_state  (n_state),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    // State moves only on an accepted byte; bytes that emit nothing still
    // advance it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= mdpp_pkg::PH_SEEK;
            r_state.seen_bracket <= 1'b0;
            r_state.match_pos    <= '0;
            r_state.still_string <= 1'b1;
            r_state.still_class  <= 1'b1;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // Valid bit of the output register: set by an accepted byte that emits,
    // cleared when the consumer takes the item and nothing replaces it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; it only loads with a new item.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_is_end     = r_out.is_end;
    assign o_type_code  = r_out.type_code;
    assign o_array_flag = r_out.array_flag;
    assign o_end_reason = r_out.end_reason;

endmodule

[sv/mdpp_step.sv]
// Next-state and result logic of the descriptor parser for one byte.
`timescale 1ns / 1ps

module mdpp_step (
    input  mdpp_pkg::t_state  i_state,
    input  logic [7:0]        i_char,
    output mdpp_pkg::t_state  o_state,
    output logic              o_emit,
    output mdpp_pkg::t_result o_result
);

    logic       w_param;
    logic [3:0] w_code;
    logic       w_end;
    logic [2:0] w_reason;
    logic [1:0] w_end_phase;
    logic       w_letter;
    logic [3:0] w_letter_code;
    logic [3:0] w_name_code;

    // Primitive type letter decode.
    always_comb begin
        w_letter      = 1'b1;
        w_letter_code = mdpp_pkg::TC_Z;
        unique case (i_char)
            mdpp_pkg::CH_Z: w_letter_code = mdpp_pkg::TC_Z;
            mdpp_pkg::CH_B: w_letter_code = mdpp_pkg::TC_B;
            mdpp_pkg::CH_C: w_letter_code = mdpp_pkg::TC_C;
            mdpp_pkg::CH_S: w_letter_code = mdpp_pkg::TC_S;
            mdpp_pkg::CH_I: w_letter_code = mdpp_pkg::TC_I;
            mdpp_pkg::CH_J: w_letter_code = mdpp_pkg::TC_J;
            mdpp_pkg::CH_F: w_letter_code = mdpp_pkg::TC_F;
            mdpp_pkg::CH_D: w_letter_code = mdpp_pkg::TC_D;
            default:        w_letter      = 1'b0;
        endcase
    end

    always_comb begin
        if (i_state.still_string && i_state.match_pos == mdpp_pkg::LEN_STRING) begin
            w_name_code = mdpp_pkg::TC_STRING;
        end else if (i_state.still_class && i_state.match_pos == mdpp_pkg::LEN_CLASS) begin
            w_name_code = mdpp_pkg::TC_CLASS;
        end else begin
            w_name_code = mdpp_pkg::TC_OBJECT;
        end
    end

    always_comb begin
        o_state     = i_state;
        w_param     = 1'b0;
        w_code      = mdpp_pkg::TC_Z;
        w_end       = 1'b0;
        w_reason    = mdpp_pkg::ER_CLOSE_PAREN;
        w_end_phase = mdpp_pkg::PH_SEEK;

        unique case (i_state.phase)
            mdpp_pkg::PH_SEEK: begin
                if (i_char == mdpp_pkg::CH_NUL) begin
                    w_end    = 1'b1;
                    w_reason = mdpp_pkg::ER_NO_OPEN_PAREN;
                end else if (i_char == mdpp_pkg::CH_LPAREN) begin
                    o_state.phase = mdpp_pkg::PH_PARAM;
                end
            end
            mdpp_pkg::PH_PARAM: begin
                if (i_char == mdpp_pkg::CH_NUL) begin
                    w_end    = 1'b1;
                    w_reason = mdpp_pkg::ER_BEFORE_PAREN;
                end else if (i_char == mdpp_pkg::CH_LBRACK) begin
                    o_state.seen_bracket = 1'b1;
                end else if (i_char == mdpp_pkg::CH_RPAREN) begin
                    w_end       = 1'b1;
                    w_end_phase = mdpp_pkg::PH_DRAIN;
                    w_reason    = i_state.seen_bracket ? mdpp_pkg::ER_BAD_LETTER
                                                       : mdpp_pkg::ER_CLOSE_PAREN;
                end else if (w_letter) begin
                    w_param = 1'b1;
                    w_code  = w_letter_code;
                end else if (i_char == mdpp_pkg::CH_L) begin
                    o_state.phase        = mdpp_pkg::PH_NAME;
                    o_state.match_pos    = '0;
                    o_state.still_string = 1'b1;
                    o_state.still_class  = 1'b1;
                end else begin
                    w_end       = 1'b1;
                    w_end_phase = mdpp_pkg::PH_DRAIN;
                    w_reason    = mdpp_pkg::ER_BAD_LETTER;
                end
            end
            mdpp_pkg::PH_NAME: begin
                if (i_char == mdpp_pkg::CH_NUL) begin
                    w_end    = 1'b1;
                    w_reason = mdpp_pkg::ER_UNTERMINATED;
                end else if (i_char == mdpp_pkg::CH_SEMI) begin
                    w_param       = 1'b1;
                    w_code        = w_name_code;
                    o_state.phase = mdpp_pkg::PH_PARAM;
                end else begin
                    if (i_state.match_pos >= mdpp_pkg::LEN_STRING ||
                        mdpp_pkg::string_char(i_state.match_pos[3:0]) != i_char) begin
                        o_state.still_string = 1'b0;
                    end
                    if (i_state.match_pos >= mdpp_pkg::LEN_CLASS ||
                        mdpp_pkg::class_char(i_state.match_pos[3:0]) != i_char) begin
                        o_state.still_class = 1'b0;
                    end
                    if (i_state.match_pos < mdpp_pkg::POS_MAX) begin
                        o_state.match_pos = i_state.match_pos + 5'd1;
                    end
                end
            end
            default: begin
                if (i_char == mdpp_pkg::CH_NUL) begin
                    o_state.phase = mdpp_pkg::PH_SEEK;
                end
            end
        endcase

        // Any emitted item starts the next parameter from a clean slate.
        if (w_param || w_end) begin
            o_state.seen_bracket = 1'b0;
            o_state.match_pos    = '0;
            o_state.still_string = 1'b1;
            o_state.still_class  = 1'b1;
        end
        if (w_end) begin
            o_state.phase = w_end_phase;
        end
    end

    assign o_emit              = w_param || w_end;
    assign o_result.is_end     = w_end;
    assign o_result.type_code  = w_param ? w_code : mdpp_pkg::TC_Z;
    assign o_result.array_flag = w_param && i_state.seen_bracket;
    assign o_result.end_reason = w_end ? w_reason : mdpp_pkg::ER_CLOSE_PAREN;

endmodule

[sv/mdpp_checker.sv]
// Port-level checker for the descriptor parser and its bind to the top level.
`timescale 1ns / 1ps

module mdpp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_is_end,
    input logic [3:0] o_type_code,
    input logic       o_array_flag,
    input logic [2:0] o_end_reason
);

    // A stalled result keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_is_end) && $stable(o_type_code) &&
                               $stable(o_array_flag) && $stable(o_end_reason))
        else $error("stalled result changed");

    // End items carry only a reason, and it is a known one.
    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_end |-> o_type_code == mdpp_pkg::TC_Z && !o_array_flag &&
                                o_end_reason <= mdpp_pkg::ER_UNTERMINATED)
        else $error("end item has bad fields");

    // Parameter items carry a known type code and no reason.
    a_param_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_end |-> o_end_reason == mdpp_pkg::ER_CLOSE_PAREN &&
                                 o_type_code <= mdpp_pkg::TC_OBJECT)
        else $error("parameter item has bad fields");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind method_descriptor_param_parser mdpp_checker u_mdpp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_is_end     (o_is_end),
    .o_type_code  (o_type_code),
    .o_array_flag (o_array_flag),
    .o_end_reason (o_end_reason)
);
